// File: src/shbhe_pkg.sv
// Package with the SHA-256 engine's constants, types and round functions.
package shbhe_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned NumRegs = 8;
   localparam logic [31:0] FillWord = 32'hDEDEDEDE;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_FILL   = 7'b0000010,
      ST_LOAD   = 7'b0000100,
      ST_ROUND  = 7'b0001000,
      ST_UPDATE = 7'b0010000,
      ST_OUTRD  = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// File: src/sha256_block_hash_engine.sv
// SHA-256 block engine: word stream in, eight-word chaining hash out per segment.
// A word that does not close a block is taken in IDLE; closing a block runs FILL for each
// missing word, LOAD of the sixteen block words, 64 rounds and the UPDATE write-back.
// The shared round unit takes no new word until the block is through, and a segment end
// adds eight result transfers, each through OUTRD and OUT.
// Reset (synchronous, active high) restores the standard initial hash and clears control.
module sha256_block_hash_engine
   import shbhe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // data_word[31:0], valid_bytes[34:32], zeros
   input  logic        req_tlast,  // last_word
   input  logic        req_tuser,  // begin_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // digest_word[31:0], digest_index[34:32], zeros
   output logic        rsp_tlast,  // digest_last
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] init_ff [8];
   logic [31:0] hash_mem [8];
   logic [31:0] blk_mem [16];
   logic [31:0] sched_ff [16];
   logic [31:0] wv_ff [8];

   state_type   state_ff, state_in;
   logic [3:0]  pos_ff, pos_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic        ovalid_ff, ovalid_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic [31:0] hash_rd_ff;
   logic [2:0]  hash_addr;
   logic        hash_we;
   logic [31:0] hash_wd;
   logic        blk_we;
   logic [3:0]  blk_addr;
   logic [31:0] blk_wd;
   logic [31:0] blk_rd_ff;
   logic [31:0] word_m;
   logic [31:0] keep;
   logic [31:0] w_cur, t1, t2;
   logic        req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;

   always_comb begin
      unique case (req_tdata[34:32])
         3'd1:    keep = 32'hFF000000;
         3'd2:    keep = 32'hFFFF0000;
         3'd3:    keep = 32'hFFFFFF00;
         default: keep = 32'hFFFFFFFF;
      endcase
      word_m = req_tlast ? ((req_tdata[31:0] & keep) | (FillWord & ~keep)) : req_tdata[31:0];
   end

   // Schedule word of the current round from the sliding window.
   assign w_cur = (rnd_ff < 6'd16) ? sched_ff[rnd_ff[3:0]]
                : sig1(sched_ff[14]) + sched_ff[9] + sig0(sched_ff[1]) + sched_ff[0];
   assign t1 = wv_ff[7] + (rotr(wv_ff[4], 6) ^ rotr(wv_ff[4], 11) ^ rotr(wv_ff[4], 25))
             + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6])) + RoundConst[rnd_ff] + w_cur;
   assign t2 = (rotr(wv_ff[0], 2) ^ rotr(wv_ff[0], 13) ^ rotr(wv_ff[0], 22))
             + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      rnd_in    = rnd_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      ovalid_in = ovalid_ff;
      oidx_in   = oidx_ff;
      hash_addr = cnt_ff[2:0];
      hash_we   = 1'b0;
      hash_wd   = hash_rd_ff + wv_ff[0];
      blk_we    = 1'b0;
      blk_addr  = cnt_ff;
      blk_wd    = FillWord;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               blk_we   = 1'b1;
               blk_addr = req_tuser ? 4'd0 : pos_ff;
               blk_wd   = word_m;
               last_in  = req_tlast;
               pos_in   = (req_tuser ? 4'd0 : pos_ff) + 4'd1;
               if (pos_in == 4'd0) begin
                  cnt_in   = 4'd0;
                  state_in = ST_LOAD;
               end else if (req_tlast) begin
                  cnt_in   = pos_in;
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            blk_we   = 1'b1;
            cnt_in   = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               cnt_in   = 4'd0;
               pos_in   = 4'd0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Reads hash word cnt and block word cnt; data arrives next cycle.
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               rnd_in   = 6'd0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               cnt_in   = 4'd0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // cnt 0 reads word 0; from cnt 1 on write word cnt-1 while reading cnt.
            hash_addr = cnt_ff[2:0];
            if (cnt_ff != 4'd0) begin
               hash_we   = 1'b1;
               hash_addr = cnt_ff[2:0] - 3'd1;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               cnt_in   = 4'd0;
               state_in = last_ff ? ST_OUTRD : ST_IDLE;
            end
         end
         ST_OUTRD: begin
            hash_addr = cnt_ff[2:0];
            ovalid_in = 1'b1;
            oidx_in   = cnt_ff[2:0];
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               ovalid_in = 1'b0;
               if (oidx_ff == 3'd7) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = {1'b0, oidx_ff + 3'd1};
                  state_in = ST_OUTRD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The hash read port is shared: UPDATE reads the next word while writing back.
   logic [2:0] hash_raddr;
   assign hash_raddr = (state_ff == ST_UPDATE) ? cnt_ff[2:0] : hash_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            init_ff[i]  <= InitHash[i];
            hash_mem[i] <= InitHash[i];
         end
      end else begin
         if (csr_we) begin
            init_ff[csr_index] <= csr_wdata;
         end
         if (req_acc && req_tuser) begin
            for (int i = 0; i < 8; i++) begin
               hash_mem[i] <= init_ff[i];
            end
         end else if (hash_we) begin
            hash_mem[hash_addr] <= hash_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      hash_rd_ff <= hash_mem[hash_raddr];
      if (blk_we) begin
         blk_mem[blk_addr] <= blk_wd;
      end
      blk_rd_ff <= blk_mem[blk_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         if (cnt_ff != 4'd0) begin
            sched_ff[cnt_ff - 4'd1] <= blk_rd_ff;
            if (cnt_ff <= 4'd8) begin
               wv_ff[cnt_ff[2:0] - 3'd1] <= hash_rd_ff;
            end
         end
      end else if (state_ff == ST_ROUND) begin
         if (rnd_ff == 6'd0) begin
            sched_ff[15] <= blk_rd_ff;
         end
         if (rnd_ff >= 6'd16) begin
            for (int i = 0; i < 15; i++) begin
               sched_ff[i] <= sched_ff[i + 1];
            end
            sched_ff[15] <= w_cur;
         end
         wv_ff[7] <= wv_ff[6];
         wv_ff[6] <= wv_ff[5];
         wv_ff[5] <= wv_ff[4];
         wv_ff[4] <= wv_ff[3] + t1;
         wv_ff[3] <= wv_ff[2];
         wv_ff[2] <= wv_ff[1];
         wv_ff[1] <= wv_ff[0];
         wv_ff[0] <= t1 + t2;
      end else if (state_ff == ST_UPDATE && cnt_ff != 4'd0) begin
         for (int i = 0; i < 7; i++) begin
            wv_ff[i] <= wv_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= 4'd0;
         rnd_ff    <= 6'd0;
         cnt_ff    <= 4'd0;
         last_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
         oidx_ff   <= 3'd0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         rnd_ff    <= rnd_in;
         cnt_ff    <= cnt_in;
         last_ff   <= last_in;
         ovalid_ff <= ovalid_in;
         oidx_ff   <= oidx_in;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {5'd0, oidx_ff, hash_rd_ff};
   assign rsp_tlast  = (oidx_ff == 3'd7);

   a_out_in_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == ST_OUT) else $error("result outside output state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> !req_tready) else $error("accept during rounds");
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd63) |=> state_ff == ST_UPDATE)
      else $error("round count overrun");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(oidx_ff))
      else $error("result dropped");

endmodule

// File: bench/sha256_block_hash_engine_checker.sv
// Checker that predicts the SHA-256 chaining hash from observed transfers and compares results.
module sha256_block_hash_engine_checker
   import shbhe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          digest_count
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_t;

   digest_t     digest_queue[$];
   logic [31:0] seed_hash[8];
   logic [31:0] chain_hash[8];
   logic [31:0] msg_block[16];
   int unsigned fill_level;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_message_block();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = msg_block[i];
      for (int i = 16; i < 64; i++) begin
         w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + v[i];
   endtask

   task automatic absorb_word(input logic [31:0] data, input logic [2:0] nbytes,
                              input logic last, input logic first);
      logic [31:0] keep;
      digest_t     d;
      if (first) begin
         chain_hash = seed_hash;
         fill_level = 0;
      end
      if (last && nbytes >= 1 && nbytes <= 3) begin
         keep = 32'hFFFFFFFF << (8 * (4 - nbytes));
         data = (data & keep) | (FillWord & ~keep);
      end
      msg_block[fill_level] = data;
      fill_level++;
      if (fill_level == 16 || last) begin
         for (int i = fill_level; i < 16; i++) msg_block[i] = FillWord;
         compress_message_block();
         fill_level = 0;
      end
      if (last) begin
         for (int i = 0; i < 8; i++) begin
            d.word = chain_hash[i];
            d.index = 3'(i);
            d.last = (i == 7);
            digest_queue.push_back(d);
         end
      end
   endtask

   initial begin
      fail_count = 0;
      digest_count = 0;
   end

   assign pending = digest_queue.size();

   always @(posedge clock) begin
      digest_t e;
      if (reset) begin
         seed_hash = InitHash;
         chain_hash = InitHash;
         fill_level = 0;
         digest_queue.delete();
      end else begin
         if (csr_we) seed_hash[csr_index] = csr_wdata;
         if (req_tvalid && req_tready)
            absorb_word(req_tdata[31:0], req_tdata[34:32], req_tlast, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            digest_count++;
            if (digest_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result transfer, actual word %h index %0d last %b",
                        $time, rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
            end else begin
               e = digest_queue.pop_front();
               if (rsp_tdata[31:0] !== e.word || rsp_tdata[34:32] !== e.index
                   || rsp_tlast !== e.last) begin
                  fail_count++;
                  $display("%0t: mismatch, expected word %h index %0d last %b, actual %h %0d %b",
                           $time, e.word, e.index, e.last,
                           rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
               end
            end
         end
      end
   end

endmodule

// File: bench/tb_sha256_block_hash_engine.sv
// Testbench top: drives word segments and register writes, and reports the verdict.
module tb_sha256_block_hash_engine;
   import shbhe_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          fail_count, pending, digest_count;
   int          word_count = 0;
   int          segment_count = 0;
   int          stall_left = 0;
   bit          quiet = 1'b0;

   always #4 clock = ~clock;

   sha256_block_hash_engine u_top (.*);

   sha256_block_hash_engine_checker u_checker (.*);

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                            input logic last, input logic first);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, nbytes, data};
      req_tlast  <= last;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      word_count++;
      if (last) segment_count++;
   endtask

   task automatic send_segment(input int len, input logic first, input logic [2:0] nbytes);
      for (int i = 0; i < len; i++)
         send_word($urandom, nbytes, i == len - 1, first && i == 0);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_seeds(input int mode);
      for (int i = 0; i < NumRegs; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         case (mode)
            0: csr_wdata <= 32'h0;
            1: csr_wdata <= 32'hFFFFFFFF;
            2: csr_wdata <= $urandom;
            default: csr_wdata <= InitHash[i];
         endcase
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Standard seeds, single-word segments covering every byte count, then multi-word segments.
      send_word(32'h00000000, 3'd4, 1'b1, 1'b1);
      send_word(32'hFFFFFFFF, 3'd4, 1'b1, 1'b1);
      for (int n = 0; n < 8; n++) send_word($urandom, 3'(n), 1'b1, 1'b1);
      send_segment(16, 1'b1, 3'd2);
      send_segment(17, 1'b1, 3'd1);
      send_word($urandom, 3'd4, 1'b0, 1'b1);
      send_word($urandom, 3'd4, 1'b0, 1'b0);
      send_segment(2, 1'b1, 3'd3);
      send_segment(2, 1'b0, 3'd4);
      wait_idle();

      write_seeds(0);
      send_segment(3, 1'b1, 3'd4);
      wait_idle();
      write_seeds(1);
      send_segment(1, 1'b1, 3'd4);
      wait_idle();
      write_seeds(2);

      for (int s = 0; word_count < 160; s++) begin
         int len;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 34) : $urandom_range(1, 8);
         if ($urandom_range(0, 9) == 0) begin
            send_word($urandom, 3'($urandom), 1'b0, 1'($urandom));
            len = $urandom_range(1, 4);
         end
         if (word_count > 135) quiet = 1'b1;
         send_segment(len, $urandom_range(0, 5) != 0, 3'($urandom));
         if (s == 6) wait_idle();
         if (s == 12) begin
            wait_idle();
            write_seeds(3);
         end
      end
      wait_idle();

      $display("Sent %0d words in %0d segments and checked %0d digest words.",
               word_count, segment_count, digest_count);
      $display("Seeds covered all zeros, all ones, random and standard values.");
      if (fail_count == 0) begin
         $display("sha256_block_hash_engine test passed");
      end else begin
         $display("sha256_block_hash_engine test failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("sha256_block_hash_engine test failed");
      $finish;
   end

endmodule
